@@ hdl/tcw_pkg.sv @@
`default_nettype none

package tcw_pkg;

    // Screen geometry.
    localparam int COLUMNS    = 80;
    localparam int ROWS       = 28;
    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int LAST_BASE  = (ROWS - 1) * COLUMNS;

    // Derived widths.
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int ADDR_W = $clog2(CELL_COUNT);

    // Fixed field widths of the words.
    localparam int INDEX_W  = 12;
    localparam int CURSOR_W = 12;
    localparam int CELL_W   = 16;
    localparam int ATTR_W   = 8;
    localparam int CHAR_W   = 8;

    // Read index limit, one bit wider than the index so the count itself fits.
    localparam logic [INDEX_W:0] CELL_LIMIT = (INDEX_W + 1)'(CELL_COUNT);

    // Character codes and reset attribute.
    localparam logic [CHAR_W-1:0] CODE_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0] CODE_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CODE_SPACE     = 8'h20;
    localparam logic [ATTR_W-1:0] ATTR_RESET     = 8'h0A;

    // Request codes.
    localparam logic [1:0] REQ_PUT   = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [CHAR_W-1:0]  char_code;
        logic [INDEX_W-1:0] cell_index;
    } in_word_t;

    typedef struct packed {
        logic [CURSOR_W-1:0] cursor_pos;
        logic [CELL_W-1:0]   cell_data;
        logic                did_scroll;
        logic                index_error;
    } out_word_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic do_put;
        logic rd_issue;
        logic copy_rd;
        logic fill_wr;
        logic fill_reset_val;
        logic ptr_zero;
        logic ptr_bottom;
        logic ptr_inc;
        logic cursor_home;
        logic out_load;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] req_type;
        logic       put_scroll;
        logic       ptr_copy_end;
        logic       ptr_store_end;
    } dp_status_t;

endpackage

`default_nettype wire

@@ hdl/tcw_ram.sv @@
`default_nettype none

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2240
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ hdl/tcw_datapath.sv @@
`default_nettype none

module tcw_datapath
    import tcw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  in_word_t          in_word,
    input  logic              cfg_wr_en,
    input  logic [ATTR_W-1:0] cfg_wr_data,
    input  ctrl_cmd_t         cmd,
    output dp_status_t        st,
    output out_word_t         out_word
);

    logic [ATTR_W-1:0]  attr_reg;
    logic [1:0]         req_reg;
    logic [CHAR_W-1:0]  char_reg;
    logic [INDEX_W-1:0] idx_reg;
    logic [COL_W-1:0]   col_reg;
    logic [COL_W-1:0]   col_next;
    logic [ROW_W-1:0]   row_reg;
    logic [ROW_W-1:0]   row_next;
    logic [ADDR_W-1:0]  ptr_reg;
    logic [ADDR_W-1:0]  ptr_next;
    logic               copy_valid_reg;
    logic [ADDR_W-1:0]  copy_addr_reg;
    logic               scroll_reg;
    logic               scroll_next;
    out_word_t          out_word_reg;

    logic [ADDR_W-1:0]  cur_pos;
    logic [CELL_W-1:0]  blank_cell;
    logic               is_nl;
    logic               is_bs;
    logic               last_col;
    logic               last_row;
    logic               col_zero;
    logic               to_next_row;
    logic               put_scroll;
    logic               idx_ok;
    logic               read_req;

    logic               ram_wr_en;
    logic [ADDR_W-1:0]  ram_wr_addr;
    logic [CELL_W-1:0]  ram_wr_data;
    logic               ram_rd_en;
    logic [ADDR_W-1:0]  ram_rd_addr;
    logic [CELL_W-1:0]  ram_rd_data;

    // Cursor position and decode of the captured request.
    assign cur_pos     = ADDR_W'(row_reg) * ADDR_W'(COLUMNS) + ADDR_W'(col_reg);
    assign blank_cell  = {attr_reg, CODE_SPACE};
    assign is_nl       = (char_reg == CODE_NEWLINE);
    assign is_bs       = (char_reg == CODE_BACKSPACE);
    assign last_col    = (col_reg == COL_W'(COLUMNS - 1));
    assign last_row    = (row_reg == ROW_W'(ROWS - 1));
    assign col_zero    = (col_reg == '0);
    assign to_next_row = is_nl || (!is_bs && last_col);
    assign put_scroll  = to_next_row && last_row;
    assign idx_ok      = ({1'b0, idx_reg} < CELL_LIMIT);
    assign read_req    = (req_reg == REQ_READ);

    // Cursor update for put and clear.
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cmd.cursor_home)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (cmd.do_put)
        begin
            if (to_next_row)
            begin
                col_next = '0;
                if (!last_row)
                begin
                    row_next = row_reg + ROW_W'(1);
                end
            end
            else if (is_bs)
            begin
                if (!col_zero)
                begin
                    col_next = col_reg - COL_W'(1);
                end
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    // Sweep address counter for scroll, clear and the reset fill.
    always_comb
    begin
        ptr_next = ptr_reg;
        if (cmd.ptr_zero)
        begin
            ptr_next = '0;
        end
        else if (cmd.ptr_bottom)
        begin
            ptr_next = ADDR_W'(LAST_BASE);
        end
        else if (cmd.ptr_inc)
        begin
            ptr_next = ptr_reg + ADDR_W'(1);
        end
    end

    // Scroll flag of the current item.
    always_comb
    begin
        scroll_next = scroll_reg;
        if (cmd.capture)
        begin
            scroll_next = 1'b0;
        end
        else if (cmd.do_put)
        begin
            scroll_next = put_scroll;
        end
    end

    // Store write port: pending copy first, then put, then sweep fill.
    always_comb
    begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = ptr_reg;
        ram_wr_data = blank_cell;
        if (copy_valid_reg)
        begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = copy_addr_reg;
            ram_wr_data = ram_rd_data;
        end
        else if (cmd.do_put && !is_nl && !is_bs)
        begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = cur_pos;
            ram_wr_data = {attr_reg, char_reg};
        end
        else if (cmd.do_put && is_bs && !col_zero)
        begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = cur_pos - ADDR_W'(1);
            ram_wr_data = blank_cell;
        end
        else if (cmd.fill_wr)
        begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = ptr_reg;
            ram_wr_data = cmd.fill_reset_val ? {ATTR_RESET, CODE_SPACE} : blank_cell;
        end
    end

    // Store read port: scroll copy source or scan-out read.
    assign ram_rd_en   = cmd.copy_rd || (cmd.rd_issue && idx_ok);
    assign ram_rd_addr = cmd.copy_rd ? (ptr_reg + ADDR_W'(COLUMNS)) : idx_reg[ADDR_W-1:0];

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELL_COUNT)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg       <= ATTR_RESET;
            col_reg        <= '0;
            row_reg        <= ROW_W'(ROWS - 1);
            ptr_reg        <= '0;
            copy_valid_reg <= 1'b0;
            scroll_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                attr_reg <= cfg_wr_data;
            end
            col_reg        <= col_next;
            row_reg        <= row_next;
            ptr_reg        <= ptr_next;
            copy_valid_reg <= cmd.copy_rd;
            scroll_reg     <= scroll_next;
        end
    end

    // Payload registers: captured request, copy target and result word.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg  <= in_word.req_type;
            char_reg <= in_word.char_code;
            idx_reg  <= in_word.cell_index;
        end
        copy_addr_reg <= ptr_reg;
        if (cmd.out_load)
        begin
            out_word_reg.cursor_pos  <= CURSOR_W'(cur_pos);
            out_word_reg.cell_data   <= (read_req && idx_ok) ? ram_rd_data : '0;
            out_word_reg.did_scroll  <= scroll_reg;
            out_word_reg.index_error <= read_req && !idx_ok;
        end
    end

    assign out_word         = out_word_reg;
    assign st.req_type      = req_reg;
    assign st.put_scroll    = put_scroll;
    assign st.ptr_copy_end  = (ptr_reg == ADDR_W'(LAST_BASE - 1));
    assign st.ptr_store_end = (ptr_reg == ADDR_W'(CELL_COUNT - 1));

`ifndef ASSERT_OFF
    // A pending copy write never meets another write request.
    assert property (@(posedge clk) disable iff (!rst_n)
        copy_valid_reg |-> !cmd.do_put && !cmd.fill_wr)
        else $error("store write port conflict");

    // The cursor stays on the screen.
    assert property (@(posedge clk) disable iff (!rst_n)
        (col_reg < COL_W'(COLUMNS)) && (row_reg < ROW_W'(ROWS)))
        else $error("cursor off screen");

    // A put that scrolls leaves the cursor at the start of the bottom row.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.do_put && put_scroll) |=> (col_reg == '0) && (row_reg == ROW_W'(ROWS - 1)))
        else $error("cursor wrong after scroll");
`endif

endmodule

`default_nettype wire

@@ hdl/tcw_ctrl.sv @@
`default_nettype none

module tcw_ctrl
    import tcw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       out_ready,
    output logic       out_valid,
    input  dp_status_t st,
    output ctrl_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_DISPATCH,
        ST_SCROLL_COPY,
        ST_SCROLL_DRAIN,
        ST_SCROLL_BLANK,
        ST_CLEAR_FILL,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    // Next state and commands.
    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg) inside
            ST_INIT:
            begin
                cmd.fill_wr        = 1'b1;
                cmd.fill_reset_val = 1'b1;
                if (st.ptr_store_end)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.ptr_inc = 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                unique case (st.req_type)
                    REQ_PUT:
                    begin
                        cmd.do_put = 1'b1;
                        if (st.put_scroll)
                        begin
                            cmd.ptr_zero = 1'b1;
                            state_next   = ST_SCROLL_COPY;
                        end
                        else
                        begin
                            state_next = ST_DONE;
                        end
                    end
                    REQ_READ:
                    begin
                        cmd.rd_issue = 1'b1;
                        state_next   = ST_DONE;
                    end
                    REQ_CLEAR:
                    begin
                        cmd.cursor_home = 1'b1;
                        cmd.ptr_zero    = 1'b1;
                        state_next      = ST_CLEAR_FILL;
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_SCROLL_COPY:
            begin
                cmd.copy_rd = 1'b1;
                if (st.ptr_copy_end)
                begin
                    cmd.ptr_bottom = 1'b1;
                    state_next     = ST_SCROLL_DRAIN;
                end
                else
                begin
                    cmd.ptr_inc = 1'b1;
                end
            end
            ST_SCROLL_DRAIN:
            begin
                state_next = ST_SCROLL_BLANK;
            end
            ST_SCROLL_BLANK, ST_CLEAR_FILL:
            begin
                cmd.fill_wr = 1'b1;
                if (st.ptr_store_end)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.ptr_inc = 1'b1;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

`ifndef ASSERT_OFF
    // A new result word is only loaded into a free or departing output slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("result word overwritten");
`endif

endmodule

`default_nettype wire

@@ hdl/text_console_writer.sv @@
`default_nettype none

// Text console writer with a COLUMNS x ROWS store of 16-bit cells (attribute
// high byte, character low byte) and a cursor. After reset the block fills
// all CELL_COUNT cells (2240 at 80 x 28) of the store with blank cells
// before in_ready rises; configuration writes are taken during that time.
// Items are processed one at a time. A step that scrolls moves the store up
// one row through the single write port of the store, one cell a cycle,
// then blanks the bottom row. A clear writes every cell once. The result
// word sits in an output register, so the next item can be accepted while
// it waits.
module text_console_writer
    import tcw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  in_word_t          in_word,
    output logic              out_valid,
    input  logic              out_ready,
    output out_word_t         out_word,
    input  logic              cfg_wr_en,
    input  logic [ATTR_W-1:0] cfg_wr_data
);

    ctrl_cmd_t  cmd;
    dp_status_t st;

    tcw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .st        (st),
        .cmd       (cmd)
    );

    tcw_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_word     (in_word),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .st          (st),
        .out_word    (out_word)
    );

endmodule

`default_nettype wire

@@ verif/text_console_writer_tb.sv @@
`timescale 1ns / 1ps

module text_console_writer_tb;
    import tcw_pkg::*;

    // The request code that the block ignores.
    localparam logic [1:0] REQ_SPARE = 2'd3;

    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 2300;
    localparam int PHASE_WORDS = 240;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    in_word_t          in_word = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    out_word_t         out_word;
    logic              cfg_wr_en = 1'b0;
    logic [ATTR_W-1:0] cfg_wr_data = '0;

    // Requests waiting to be sent and replies waiting to arrive.
    in_word_t  request_q[$];
    out_word_t reply_q[$];

    // Console state as the block should hold it.
    logic [CELL_W-1:0] screen[CELL_COUNT];
    logic [COL_W-1:0]  cur_col;
    logic [ROW_W-1:0]  cur_row;
    logic [ATTR_W-1:0] cell_attr;

    int   queued_count = 0;
    int   replies_seen = 0;
    int   mismatches = 0;
    int   tx_gap = 0;
    int   rx_wait = 0;
    int   quiet_cycles = 0;
    logic tx_steady = 1'b0;
    logic rx_steady = 1'b0;
    logic hold_pending = 1'b0;

    text_console_writer u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_word     (in_word),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_word    (out_word),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic logic [CELL_W-1:0] blank_cell();
        return {cell_attr, CODE_SPACE};
    endfunction

    // Blank every cell from the given one to the end of the store.
    function automatic void blank_from(int first);
        int i;
        for (i = first; i < CELL_COUNT; i++)
            screen[i] = blank_cell();
    endfunction

    // Move to the start of the next row, scrolling when already on the bottom.
    function automatic logic next_line();
        int i;
        cur_col = '0;
        if (cur_row == ROW_W'(ROWS - 1))
        begin
            for (i = 0; i < LAST_BASE; i++)
                screen[i] = screen[i + COLUMNS];
            blank_from(LAST_BASE);
            return 1'b1;
        end
        cur_row = cur_row + 1'b1;
        return 1'b0;
    endfunction

    // Apply one request to the console state and return the reply it gives.
    function automatic out_word_t console_apply(in_word_t w);
        out_word_t r;
        r = '0;
        case (w.req_type)
            REQ_PUT:
            begin
                if (w.char_code == CODE_NEWLINE)
                begin
                    r.did_scroll = next_line();
                end
                else if (w.char_code == CODE_BACKSPACE)
                begin
                    // At column zero a backspace changes nothing.
                    if (cur_col != '0)
                    begin
                        cur_col = cur_col - 1'b1;
                        screen[int'(cur_row) * COLUMNS + int'(cur_col)] = blank_cell();
                    end
                end
                else
                begin
                    screen[int'(cur_row) * COLUMNS + int'(cur_col)] = {cell_attr, w.char_code};
                    cur_col = cur_col + 1'b1;
                    if (cur_col == COL_W'(COLUMNS))
                        r.did_scroll = next_line();
                end
            end
            REQ_READ:
            begin
                if ({1'b0, w.cell_index} < CELL_LIMIT)
                    r.cell_data = screen[w.cell_index];
                else
                    r.index_error = 1'b1;
            end
            REQ_CLEAR:
            begin
                blank_from(0);
                cur_col = '0;
                cur_row = '0;
            end
            default:
            begin
            end
        endcase
        r.cursor_pos = CURSOR_W'(int'(cur_row) * COLUMNS + int'(cur_col));
        return r;
    endfunction

    task automatic report_mismatch(string what);
        mismatches++;
        if (mismatches <= 100)
            $display("ERROR: %s", what);
    endtask

    task automatic push_req(logic [1:0] kind, logic [CHAR_W-1:0] ch,
                            logic [INDEX_W-1:0] idx);
        in_word_t w;
        w.req_type   = kind;
        w.char_code  = ch;
        w.cell_index = idx;
        request_q.push_back(w);
        queued_count++;
    endtask

    // Random traffic: mostly lines of text, with reads, backspaces, clears
    // and some malformed or ignored requests mixed in.
    task automatic queue_random(int count);
        int stop_at;
        int kind;
        int len;
        int i;
        int r;
        logic [CHAR_W-1:0]  ch;
        logic [INDEX_W-1:0] idx;
        stop_at = queued_count + count;
        while (queued_count < stop_at)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 55)
            begin
                // A line of text, now and then longer than a row.
                if ($urandom_range(0, 9) == 0)
                    len = $urandom_range(60, 100);
                else
                    len = $urandom_range(1, 24);
                for (i = 0; i < len; i++)
                begin
                    if ($urandom_range(0, 19) == 0)
                        ch = CHAR_W'($urandom_range(0, 255));
                    else
                        ch = CHAR_W'($urandom_range(8'h20, 8'h7E));
                    push_req(REQ_PUT, ch, INDEX_W'($urandom_range(0, 4095)));
                end
                if ($urandom_range(0, 9) < 6)
                    push_req(REQ_PUT, CODE_NEWLINE, INDEX_W'($urandom_range(0, 4095)));
            end
            else if (kind < 67)
            begin
                len = $urandom_range(1, 5);
                for (i = 0; i < len; i++)
                    push_req(REQ_PUT, CODE_BACKSPACE, INDEX_W'($urandom_range(0, 4095)));
            end
            else if (kind < 90)
            begin
                // Reads anywhere, near the bottom rows, or past the last cell.
                len = $urandom_range(1, 6);
                for (i = 0; i < len; i++)
                begin
                    r = $urandom_range(0, 9);
                    if (r < 5)
                        idx = INDEX_W'($urandom_range(0, CELL_COUNT - 1));
                    else if (r < 8)
                        idx = INDEX_W'(LAST_BASE - COLUMNS
                                       + $urandom_range(0, 2 * COLUMNS - 1));
                    else
                        idx = INDEX_W'($urandom_range(CELL_COUNT, 4095));
                    push_req(REQ_READ, CHAR_W'($urandom_range(0, 255)), idx);
                end
            end
            else if (kind < 94)
            begin
                push_req(2'($urandom_range(0, 3)), CHAR_W'($urandom_range(0, 255)),
                         INDEX_W'($urandom_range(0, 4095)));
            end
            else if (kind < 96)
            begin
                push_req(REQ_CLEAR, CHAR_W'($urandom_range(0, 255)),
                         INDEX_W'($urandom_range(0, 4095)));
            end
            else
            begin
                push_req(REQ_SPARE, CHAR_W'($urandom_range(0, 255)),
                         INDEX_W'($urandom_range(0, 4095)));
            end
        end
    endtask

    // Request driver: predicts each word as it is taken, then offers the
    // next one after its drawn gap.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_word  <= '0;
            tx_gap   <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                reply_q.push_back(console_apply(in_word));
            if (!in_valid || in_ready)
            begin
                if (tx_gap != 0)
                begin
                    tx_gap   <= tx_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (request_q.size() != 0)
                begin
                    in_word  <= request_q.pop_front();
                    in_valid <= 1'b1;
                    tx_gap   <= tx_steady ? 0 : $urandom_range(0, 10);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Reply monitor: checks each word against the oldest prediction and
    // draws how long to hold off before taking the next one.
    always @(posedge clk or negedge rst_n)
    begin : reply_monitor
        out_word_t want;
        int        pause;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_wait   <= 0;
        end
        else if (out_valid && out_ready)
        begin
            if (reply_q.size() == 0)
            begin
                report_mismatch($sformatf("reply %0h arrived with nothing predicted",
                                          out_word));
            end
            else
            begin
                want = reply_q.pop_front();
                if (out_word.cursor_pos !== want.cursor_pos)
                    report_mismatch($sformatf("reply %0d: cursor_pos %0d, predicted %0d",
                                              replies_seen, out_word.cursor_pos,
                                              want.cursor_pos));
                if (out_word.cell_data !== want.cell_data)
                    report_mismatch($sformatf("reply %0d: cell_data %h, predicted %h",
                                              replies_seen, out_word.cell_data,
                                              want.cell_data));
                if (out_word.did_scroll !== want.did_scroll)
                    report_mismatch($sformatf("reply %0d: did_scroll %b, predicted %b",
                                              replies_seen, out_word.did_scroll,
                                              want.did_scroll));
                if (out_word.index_error !== want.index_error)
                    report_mismatch($sformatf("reply %0d: index_error %b, predicted %b",
                                              replies_seen, out_word.index_error,
                                              want.index_error));
                replies_seen++;
            end
            // A long hold-off lets the block fill up and stall its input.
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                pause = HOLD_CYCLES;
            end
            else
            begin
                pause = rx_steady ? 0 : $urandom_range(0, 10);
            end
            rx_wait   <= pause;
            out_ready <= (pause == 0);
        end
        else if (!out_ready)
        begin
            if (rx_wait <= 1)
                out_ready <= 1'b1;
            else
                rx_wait <= rx_wait - 1;
        end
    end

    // Ends the run if no word moves on either side for too long.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles == STALL_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        int                i;
        int                p;
        logic [ATTR_W-1:0] phase_attr;

        cell_attr = ATTR_RESET;
        cur_col   = '0;
        cur_row   = ROW_W'(ROWS - 1);
        blank_from(0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Reads of the freshly reset store, at both ends and past the last cell.
        push_req(REQ_READ, 8'h00, '0);
        push_req(REQ_READ, 8'hFF, INDEX_W'(CELL_COUNT - 1));
        push_req(REQ_READ, 8'h00, INDEX_W'(CELL_COUNT));
        push_req(REQ_READ, 8'hFF, '1);

        // A full bottom row: the last put wraps past the bottom and scrolls.
        push_req(REQ_PUT, 8'h00, '1);
        push_req(REQ_PUT, 8'hFF, '0);
        for (i = 2; i < COLUMNS; i++)
            push_req(REQ_PUT, CHAR_W'($urandom_range(8'h20, 8'h7E)), '0);
        push_req(REQ_READ, 8'h00, INDEX_W'(LAST_BASE - COLUMNS));
        push_req(REQ_READ, 8'h00, INDEX_W'(LAST_BASE - 1));
        push_req(REQ_READ, 8'h00, INDEX_W'(LAST_BASE));

        // Backspace steps back and blanks; at column zero it does nothing.
        push_req(REQ_PUT, 8'h41, '0);
        push_req(REQ_PUT, 8'h42, '0);
        push_req(REQ_PUT, CODE_BACKSPACE, '0);
        push_req(REQ_READ, 8'h00, INDEX_W'(LAST_BASE + 1));
        push_req(REQ_PUT, CODE_BACKSPACE, '0);
        push_req(REQ_PUT, CODE_BACKSPACE, '0);
        push_req(REQ_SPARE, 8'hFF, '1);

        // Newline on the bottom row scrolls; clear homes the cursor.
        push_req(REQ_PUT, CODE_NEWLINE, '0);
        push_req(REQ_READ, 8'h00, INDEX_W'(LAST_BASE - COLUMNS + 1));
        push_req(REQ_CLEAR, 8'h5A, 12'h5A5);
        push_req(REQ_PUT, CODE_BACKSPACE, '0);
        push_req(REQ_PUT, CODE_NEWLINE, '0);
        push_req(REQ_READ, 8'h00, '0);

        // Random phases, each under a newly written attribute and one of several idling patterns.
        for (p = 0; p < 5; p++)
        begin
            while (replies_seen < queued_count)
                @(posedge clk);
            if (p == 0)
                phase_attr = 8'hFF;
            else if (p == 1)
                phase_attr = 8'h00;
            else
                phase_attr = ATTR_W'($urandom_range(0, 255));
            @(posedge clk);
            cfg_wr_en   <= 1'b1;
            cfg_wr_data <= phase_attr;
            @(posedge clk);
            cfg_wr_en <= 1'b0;
            cell_attr = phase_attr;

            tx_steady    = (p == 1 || p == 2);
            rx_steady    = (p == 2);
            hold_pending = (p == 1 || p == 3);
            queue_random(PHASE_WORDS);
        end

        while (replies_seen < queued_count)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (reply_q.size() != 0)
            report_mismatch($sformatf("%0d predicted replies never arrived", reply_q.size()));

        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ files.f @@
hdl/tcw_pkg.sv
hdl/tcw_ram.sv
hdl/tcw_datapath.sv
hdl/tcw_ctrl.sv
hdl/text_console_writer.sv
verif/text_console_writer_tb.sv
